// File: hw/rtl/mau_pkg.sv
// matrix arithmetic unit package: sizes, codes, state and control types
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package mau_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int DIM_W     = 5;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_SUB     = 2'd1,
        OP_SCALE   = 2'd2,
        OP_PRODUCT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_WRITE_A = 2'd0,
        MODE_WRITE_B = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIM   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_DONE = 2'd2
    } state_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALAR    = 3'd5;

    typedef struct packed {
        logic clear;
        logic valid;
        op_t  op;
    } mac_ctrl_t;

    // dimensions above the store size saturate, zero stays zero
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

endpackage

// File: hw/rtl/mau_if.sv
// valid/ready channel interfaces for the matrix arithmetic unit
// depends on mau_pkg for field widths
`timescale 1ns / 1ps

interface mau_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       mode;
    logic [mau_pkg::IDX_W-1:0]        row;
    logic [mau_pkg::IDX_W-1:0]        col;
    logic signed [mau_pkg::DATA_W-1:0] value;

    modport source (output valid, output mode, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input mode, input row, input col, input value,
                    output ready);
endinterface

interface mau_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [mau_pkg::DATA_W-1:0] result;
    logic [1:0]                       status;

    modport source (output valid, output result, output status, input ready);
    modport sink   (input valid, input result, input status, output ready);
endinterface

// File: hw/rtl/mau_mac.sv
// shared arithmetic unit: one add/subtract/multiply stage and an accumulator
// depends on mau_pkg for mac_ctrl_t and op_t
`timescale 1ns / 1ps

module mau_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mau_pkg::mac_ctrl_t        ctrl,
    input  logic [mau_pkg::DATA_W-1:0] a_data,
    input  logic [mau_pkg::DATA_W-1:0] b_data,
    input  logic [mau_pkg::DATA_W-1:0] scalar,
    output logic [mau_pkg::DATA_W-1:0] acc,
    output logic                      busy
);

    logic [mau_pkg::DATA_W-1:0] mul_b;
    logic [mau_pkg::DATA_W-1:0] prod;
    logic [mau_pkg::DATA_W-1:0] f_next;
    logic [mau_pkg::DATA_W-1:0] f_reg;
    logic                       f_valid_reg;
    logic [mau_pkg::DATA_W-1:0] acc_reg;

    assign mul_b = (ctrl.op == mau_pkg::OP_SCALE) ? scalar : b_data;
    assign prod  = a_data * mul_b;

    always_comb
    begin
        case (ctrl.op)
            mau_pkg::OP_ADD:  f_next = a_data + b_data;
            mau_pkg::OP_SUB:  f_next = a_data - b_data;
            default:          f_next = prod;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            f_valid_reg <= ctrl.valid;
            if (ctrl.clear)
                acc_reg <= '0;
            else if (f_valid_reg)
                acc_reg <= acc_reg + f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
            f_reg <= f_next;
    end

    assign acc  = acc_reg;
    assign busy = f_valid_reg;

endmodule

// File: hw/rtl/matrix_arithmetic_unit.sv
// Integer matrix unit: matrices A and B (up to 16 by 16, 32-bit entries) are loaded one
// word at a time and a compute word returns one element of A+B, A-B, A*scalar or the
// matrix product A*B, wrapping in 32 bits, with status 0 ok, 1 dimension mismatch or
// 2 index outside the result size (result zero on error). A compute word sums n terms,
// where n is cols_a for the product and 1 for the other operations, through the single
// multiply-accumulate unit fed by one read port of each store, one term per cycle.
// Errors skip the multiply-accumulate unit. Input is not ready while a compute word
// is in progress.
// Top level; depends on mau_pkg, mau_in_if, mau_out_if and mau_mac.
`timescale 1ns / 1ps

module matrix_arithmetic_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mau_pkg::DATA_W-1:0]    cfg_data,
    mau_in_if.sink                        in_ch,
    mau_out_if.source                     out_ch
);

    // configuration
    mau_pkg::op_t                 operation_reg;
    logic [mau_pkg::DIM_W-1:0]    rows_a_reg;
    logic [mau_pkg::DIM_W-1:0]    cols_a_reg;
    logic [mau_pkg::DIM_W-1:0]    rows_b_reg;
    logic [mau_pkg::DIM_W-1:0]    cols_b_reg;
    logic [mau_pkg::DATA_W-1:0]   scalar_reg;

    // sequencer
    mau_pkg::state_t              state_reg, state_next;
    logic [mau_pkg::CNT_W-1:0]    k_reg, k_next;
    logic [mau_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [mau_pkg::IDX_W-1:0]    row_reg, row_next;
    logic [mau_pkg::IDX_W-1:0]    col_reg, col_next;
    mau_pkg::status_t             status_reg, status_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         out_valid_reg, out_valid_next;
    logic [mau_pkg::DATA_W-1:0]   out_result_reg, out_result_next;
    mau_pkg::status_t             out_status_reg, out_status_next;

    // stores
    logic [mau_pkg::DATA_W-1:0]   mem_a [mau_pkg::DEPTH];
    logic [mau_pkg::DATA_W-1:0]   mem_b [mau_pkg::DEPTH];
    logic [mau_pkg::DATA_W-1:0]   rd_a_reg;
    logic [mau_pkg::DATA_W-1:0]   rd_b_reg;
    logic [mau_pkg::ADDR_W-1:0]   wr_addr;
    logic [mau_pkg::ADDR_W-1:0]   rd_addr_a;
    logic [mau_pkg::ADDR_W-1:0]   rd_addr_b;
    logic                         wr_a;
    logic                         wr_b;

    logic                         in_fire;
    logic                         issue;
    logic                         load_out;
    logic                         dim_ok;
    logic [mau_pkg::DIM_W-1:0]    ra, ca, rb, cb;
    logic [mau_pkg::DIM_W-1:0]    res_rows, res_cols;
    mau_pkg::mac_ctrl_t           mac_ctrl;
    logic [mau_pkg::DATA_W-1:0]   mac_acc;
    logic                         mac_busy;

    assign ra = mau_pkg::eff_dim(rows_a_reg);
    assign ca = mau_pkg::eff_dim(cols_a_reg);
    assign rb = mau_pkg::eff_dim(rows_b_reg);
    assign cb = mau_pkg::eff_dim(cols_b_reg);

    always_comb
    begin
        case (operation_reg)
            mau_pkg::OP_ADD, mau_pkg::OP_SUB:
            begin
                dim_ok   = (ra == rb) && (ca == cb);
                res_rows = ra;
                res_cols = ca;
            end
            mau_pkg::OP_SCALE:
            begin
                dim_ok   = 1'b1;
                res_rows = ra;
                res_cols = ca;
            end
            default:
            begin
                dim_ok   = (ca == rb);
                res_rows = ra;
                res_cols = cb;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= mau_pkg::OP_ADD;
            rows_a_reg    <= mau_pkg::DIM_W'(1);
            cols_a_reg    <= mau_pkg::DIM_W'(1);
            rows_b_reg    <= mau_pkg::DIM_W'(1);
            cols_b_reg    <= mau_pkg::DIM_W'(1);
            scalar_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mau_pkg::CFG_OPERATION: operation_reg <= mau_pkg::op_t'(cfg_data[1:0]);
                mau_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::CFG_COLS_A:    cols_a_reg    <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::CFG_ROWS_B:    rows_b_reg    <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data[mau_pkg::DIM_W-1:0];
                mau_pkg::CFG_SCALAR:    scalar_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == mau_pkg::S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign wr_addr = {in_ch.row, in_ch.col};
    assign wr_a    = in_fire && (in_ch.mode == mau_pkg::MODE_WRITE_A);
    assign wr_b    = in_fire && (in_ch.mode == mau_pkg::MODE_WRITE_B);

    // product walks row of A and column of B, the rest read one element
    assign rd_addr_a = (operation_reg == mau_pkg::OP_PRODUCT) ?
                       {row_reg, k_reg[mau_pkg::IDX_W-1:0]} : {row_reg, col_reg};
    assign rd_addr_b = (operation_reg == mau_pkg::OP_PRODUCT) ?
                       {k_reg[mau_pkg::IDX_W-1:0], col_reg} : {row_reg, col_reg};

    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[wr_addr] <= in_ch.value;
        rd_a_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
            mem_b[wr_addr] <= in_ch.value;
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        status_next     = status_reg;
        rd_valid_next   = 1'b0;
        issue           = 1'b0;
        load_out        = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.valid  = rd_valid_reg;
        mac_ctrl.op     = operation_reg;
        out_result_next = out_result_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        case (state_reg)
            mau_pkg::S_IDLE:
            begin
                if (in_fire && (in_ch.mode == mau_pkg::MODE_COMPUTE))
                begin
                    mac_ctrl.clear = 1'b1;
                    row_next       = in_ch.row;
                    col_next       = in_ch.col;
                    k_next         = '0;
                    n_next         = (operation_reg == mau_pkg::OP_PRODUCT) ?
                                     mau_pkg::CNT_W'(ca) : mau_pkg::CNT_W'(1);
                    if (!dim_ok)
                    begin
                        status_next = mau_pkg::ST_DIM;
                        state_next  = mau_pkg::S_DONE;
                    end
                    else if ((mau_pkg::DIM_W'(in_ch.row) >= res_rows) ||
                             (mau_pkg::DIM_W'(in_ch.col) >= res_cols))
                    begin
                        status_next = mau_pkg::ST_RANGE;
                        state_next  = mau_pkg::S_DONE;
                    end
                    else
                    begin
                        status_next = mau_pkg::ST_OK;
                        state_next  = mau_pkg::S_RUN;
                    end
                end
            end
            mau_pkg::S_RUN:
            begin
                issue         = (k_reg < n_reg);
                rd_valid_next = issue;
                if (issue)
                    k_next = k_reg + mau_pkg::CNT_W'(1);
                else if (!rd_valid_reg && !mac_busy)
                    state_next = mau_pkg::S_DONE;
            end
            mau_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_result_next = (status_reg == mau_pkg::ST_OK) ? mac_acc : '0;
                    state_next      = mau_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mau_pkg::S_IDLE;
            k_reg         <= '0;
            n_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= mau_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        out_result_reg <= out_result_next;
        out_status_reg <= out_status_next;
    end

    mau_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (rd_a_reg),
        .b_data (rd_b_reg),
        .scalar (scalar_reg),
        .acc    (mac_acc),
        .busy   (mac_busy)
    );

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.result = out_result_reg;
    assign out_ch.status = out_status_reg;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status != mau_pkg::ST_OK)) |-> (out_ch.result == '0))
        else $error("error word carries a nonzero result");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= n_reg)
        else $error("term counter ran past the term count");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mau_pkg::S_RUN && state_next == mau_pkg::S_DONE) |->
        (!rd_valid_reg && !mac_busy))
        else $error("sequencer finished with terms still in flight");

    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg == mau_pkg::S_IDLE) && out_ch.valid)
        else $error("result load did not present a word");
`endif

endmodule

// File: test/tb.sv
// self-checking bench for matrix_arithmetic_unit: element loads, computes and register phases
// depends on mau_pkg, mau_in_if, mau_out_if and the rtl top level
`timescale 1ns / 1ps

module tb;
    import mau_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RESULT_WAIT  = 4000;
    localparam int SETTLE       = 30;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_WORDS  = 150;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } mat_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        status_t           status;
    } elem_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    mau_in_if  in_ch ();
    mau_out_if out_ch ();

    matrix_arithmetic_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mat_word_t mat_words[$];
    elem_t     predicted_elems[$];
    mat_word_t next_word;

    logic [DATA_W-1:0] shadow_a [DEPTH];
    logic [DATA_W-1:0] shadow_b [DEPTH];
    op_t               cfg_op;
    logic [DIM_W-1:0]  cfg_rows_a;
    logic [DIM_W-1:0]  cfg_cols_a;
    logic [DIM_W-1:0]  cfg_rows_b;
    logic [DIM_W-1:0]  cfg_cols_b;
    logic [DATA_W-1:0] cfg_scalar;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap;
    int snk_gap;
    int err_cnt = 0;
    int cycle_cnt = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

    function automatic logic [DIM_W-1:0] result_rows();
        return clamp_dim(cfg_rows_a);
    endfunction

    function automatic logic [DIM_W-1:0] result_cols();
        return (cfg_op == OP_PRODUCT) ? clamp_dim(cfg_cols_b) : clamp_dim(cfg_cols_a);
    endfunction

    function automatic void predict_word(logic [1:0] mode, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col, logic [DATA_W-1:0] value);
        logic [DIM_W-1:0]  ra;
        logic [DIM_W-1:0]  ca;
        logic [DIM_W-1:0]  rb;
        logic [DIM_W-1:0]  cb;
        logic [DATA_W-1:0] acc;
        logic              dims_ok;
        elem_t             e;
        ra = clamp_dim(cfg_rows_a);
        ca = clamp_dim(cfg_cols_a);
        rb = clamp_dim(cfg_rows_b);
        cb = clamp_dim(cfg_cols_b);
        if (mode == MODE_WRITE_A)
            shadow_a[{row, col}] = value;
        else if (mode == MODE_WRITE_B)
            shadow_b[{row, col}] = value;
        else if (mode == MODE_COMPUTE)
        begin
            case (cfg_op)
                OP_ADD, OP_SUB: dims_ok = (ra == rb) && (ca == cb);
                OP_SCALE:       dims_ok = 1'b1;
                default:        dims_ok = (ca == rb);
            endcase
            acc = '0;
            if (!dims_ok)
                e.status = ST_DIM;
            else if (DIM_W'(row) >= result_rows() || DIM_W'(col) >= result_cols())
                e.status = ST_RANGE;
            else
            begin
                e.status = ST_OK;
                case (cfg_op)
                    OP_ADD:   acc = shadow_a[{row, col}] + shadow_b[{row, col}];
                    OP_SUB:   acc = shadow_a[{row, col}] - shadow_b[{row, col}];
                    OP_SCALE: acc = shadow_a[{row, col}] * cfg_scalar;
                    default:
                    begin
                        for (int k = 0; k < ca; k++)
                            acc = acc + shadow_a[{row, IDX_W'(k)}] * shadow_b[{IDX_W'(k), col}];
                    end
                endcase
            end
            e.result = acc;
            predicted_elems.push_back(e);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    task automatic check_elem(logic [DATA_W-1:0] result, logic [1:0] status);
        elem_t e;
        if (predicted_elems.size() == 0)
            report_mismatch($sformatf("result %h with nothing predicted", result));
        else
        begin
            e = predicted_elems.pop_front();
            if (result !== e.result)
                report_mismatch($sformatf("result got %h want %h", result, e.result));
            if (status !== e.status)
                report_mismatch($sformatf("status field got %0d want %0d", status, e.status));
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.mode  <= '0;
            in_ch.row   <= '0;
            in_ch.col   <= '0;
            in_ch.value <= '0;
            src_gap     <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_word(in_ch.mode, in_ch.row, in_ch.col, in_ch.value);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap     <= src_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (mat_words.size() > 0 && $urandom_range(0, 99) < src_idle_pct)
                begin
                    src_gap     <= $urandom_range(0, 13);
                    in_ch.valid <= 1'b0;
                end
                else if (mat_words.size() > 0)
                begin
                    next_word    = mat_words.pop_front();
                    in_ch.mode  <= next_word.mode;
                    in_ch.row   <= next_word.row;
                    in_ch.col   <= next_word.col;
                    in_ch.value <= next_word.value;
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_elem(out_ch.result, out_ch.status);
            if (snk_gap > 0)
            begin
                snk_gap      <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < snk_idle_pct)
            begin
                snk_gap      <= $urandom_range(0, 13);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_word(logic [1:0] mode, int row, int col,
                                      logic [DATA_W-1:0] value);
        mat_word_t w;
        w.mode  = mode;
        w.row   = IDX_W'(row);
        w.col   = IDX_W'(col);
        w.value = value;
        mat_words.push_back(w);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(op_t op, int ra, int ca, int rb, int cb, logic [DATA_W-1:0] sc);
        write_reg(CFG_OPERATION, DATA_W'(op));
        write_reg(CFG_ROWS_A, DATA_W'(ra));
        write_reg(CFG_COLS_A, DATA_W'(ca));
        write_reg(CFG_ROWS_B, DATA_W'(rb));
        write_reg(CFG_COLS_B, DATA_W'(cb));
        write_reg(CFG_SCALAR, sc);
        cfg_op     = op;
        cfg_rows_a = DIM_W'(ra);
        cfg_cols_a = DIM_W'(ca);
        cfg_rows_b = DIM_W'(rb);
        cfg_cols_b = DIM_W'(cb);
        cfg_scalar = sc;
    endtask

    // block is idle once every word went in and every result came back
    task automatic wait_idle();
        int n;
        while (mat_words.size() > 0 || in_ch.valid)
            @(negedge clk);
        n = 0;
        while (predicted_elems.size() > 0 && n < RESULT_WAIT)
        begin
            @(posedge clk);
            n++;
        end
        while (predicted_elems.size() > 0)
        begin
            void'(predicted_elems.pop_front());
            report_mismatch("predicted result never arrived");
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(int n_words, bit quiet);
        int ra;
        int ca;
        int rb;
        int cb;
        int r;
        op_t op;
        op = op_t'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 80)
        begin
            ra = $urandom_range(1, MAX_DIM);
            ca = $urandom_range(1, MAX_DIM);
            rb = $urandom_range(1, MAX_DIM);
            cb = $urandom_range(1, MAX_DIM);
            if (op == OP_ADD || op == OP_SUB)
            begin
                rb = ra;
                cb = ca;
            end
            else if (op == OP_PRODUCT)
                rb = ca;
        end
        else
        begin
            ra = $urandom_range(0, 31);
            ca = $urandom_range(0, 31);
            rb = $urandom_range(0, 31);
            cb = $urandom_range(0, 31);
        end
        configure(op, ra, ca, rb, cb, pick_value());
        src_idle_pct = quiet ? 0 : $urandom_range(0, 40);
        snk_idle_pct = quiet ? 0 : $urandom_range(0, 40);
        for (int i = 0; i < n_words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                push_word(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                          pick_value());
            else if (r < 35)
                push_word((r < 19) ? MODE_WRITE_A : MODE_WRITE_B, $urandom_range(0, 15),
                          $urandom_range(0, 15), pick_value());
            else if (r < 88 && result_rows() > 0 && result_cols() > 0)
                push_word(MODE_COMPUTE, $urandom_range(0, result_rows() - 1),
                          $urandom_range(0, result_cols() - 1), pick_value());
            else
                push_word(MODE_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                          pick_value());
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cfg_op       = OP_ADD;
        cfg_rows_a   = 1;
        cfg_cols_a   = 1;
        cfg_rows_b   = 1;
        cfg_cols_b   = 1;
        cfg_scalar   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // fill both stores so no compute reads an unwritten entry
        src_idle_pct = 20;
        snk_idle_pct = 20;
        for (int i = 0; i < DEPTH; i++)
            push_word(MODE_WRITE_A, i / MAX_DIM, i % MAX_DIM, pick_value());
        for (int i = 0; i < DEPTH; i++)
            push_word(MODE_WRITE_B, i / MAX_DIM, i % MAX_DIM, pick_value());
        wait_idle();

        // full size add with wrap and corner indexes
        configure(OP_ADD, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, '0);
        push_word(MODE_WRITE_A, 15, 15, 32'h7fff_ffff);
        push_word(MODE_WRITE_B, 15, 15, 32'h0000_0001);
        push_word(MODE_COMPUTE, 15, 15, '0);
        push_word(MODE_WRITE_A, 0, 0, 32'h8000_0000);
        push_word(MODE_WRITE_B, 0, 0, 32'h8000_0000);
        push_word(MODE_COMPUTE, 0, 0, '1);
        push_word(MODE_COMPUTE, 0, 15, '0);
        push_word(MODE_UNUSED, 15, 15, '1);
        push_word(MODE_COMPUTE, 15, 0, '0);
        wait_idle();

        configure(OP_SUB, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, '0);
        push_word(MODE_COMPUTE, 0, 0, '0);
        push_word(MODE_COMPUTE, 15, 15, '0);
        wait_idle();

        // scale skips the dimension check; write past the configured size still lands
        configure(OP_SCALE, 2, 3, 5, 7, 32'h8000_0000);
        push_word(MODE_COMPUTE, 1, 2, '0);
        push_word(MODE_COMPUTE, 2, 0, '0);
        push_word(MODE_COMPUTE, 0, 3, '0);
        push_word(MODE_WRITE_A, 15, 15, '1);
        wait_idle();

        configure(OP_SCALE, MAX_DIM, MAX_DIM, 1, 1, '1);
        push_word(MODE_COMPUTE, 15, 15, '0);
        wait_idle();

        configure(OP_PRODUCT, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, '0);
        push_word(MODE_COMPUTE, 15, 15, '0);
        push_word(MODE_COMPUTE, 0, 0, '0);
        wait_idle();

        // saturated dimensions match, zero columns put every index out of range
        configure(OP_PRODUCT, 31, 17, MAX_DIM, 0, '0);
        push_word(MODE_COMPUTE, 0, 0, '0);
        wait_idle();

        // dimension error wins over range error
        configure(OP_PRODUCT, 2, 3, 4, 2, '0);
        push_word(MODE_COMPUTE, 15, 15, '0);
        push_word(MODE_COMPUTE, 0, 0, '0);
        wait_idle();

        configure(OP_ADD, 2, 4, 3, 4, '0);
        push_word(MODE_COMPUTE, 0, 0, '0);
        wait_idle();

        configure(OP_ADD, 0, 0, 0, 0, 32'h7fff_ffff);
        push_word(MODE_COMPUTE, 0, 0, '0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_WORDS, p == RANDOM_PHASES - 1);

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: matrix_arithmetic_unit.f
hw/rtl/mau_pkg.sv
hw/rtl/mau_if.sv
hw/rtl/mau_mac.sv
hw/rtl/matrix_arithmetic_unit.sv
test/tb.sv
